// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while reset is asserted (active low).
`define BTPG_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define BTPG_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== src/btpg_pkg.sv =====
// Shared constants and types of the block test pattern generator.
package btpg_pkg;

    // Default geometry limits (top-level parameter defaults).
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int TILE_MAX_DEF   = 64;

    // Depth of the internal transaction queues.
    localparam int QUEUE_DEPTH = 4;

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_MODE         = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_SIZE   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_TILE_WIDTH   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_TILE_HEIGHT  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_RANDOM_SEED  = 3'd6;

    // Pattern modes.
    localparam logic [2:0] MODE_BLACK   = 3'd0;
    localparam logic [2:0] MODE_WHITE   = 3'd1;
    localparam logic [2:0] MODE_CHECKER = 3'd2;
    localparam logic [2:0] MODE_STRIPES = 3'd3;
    localparam logic [2:0] MODE_RANDOM  = 3'd4;
    localparam logic [2:0] MODE_TILED   = 3'd5;

    // Input actions.
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_LOAD  = 1'b1;

    // Register reset values.
    localparam logic [2:0]  RST_MODE         = MODE_BLACK;
    localparam logic [7:0]  RST_BLOCK_SIZE   = 8'd8;
    localparam logic [10:0] RST_FRAME_WIDTH  = 11'd1024;
    localparam logic [10:0] RST_FRAME_HEIGHT = 11'd768;
    localparam logic [6:0]  RST_TILE_WIDTH   = 7'd8;
    localparam logic [6:0]  RST_TILE_HEIGHT  = 7'd8;
    localparam logic [15:0] RST_SEED         = 16'd44257;

    localparam logic [7:0] PIX_WHITE = 8'hFF;
    localparam logic [7:0] PIX_BLACK = 8'h00;

    // Per-transaction flags carried from front to back.
    typedef struct packed {
        logic is_load;   // tile store write, no pixel out
        logic tile_bit;  // bit to store on a load
        logic rand_we;   // first pixel of a block on its first row
        logic rand_bit;  // fresh LFSR bit for the line store
        logic col_par;   // block column parity
        logic row_par;   // block row parity
        logic eol;
        logic eof;
    } t_flags;

    localparam int FLAGS_W = $bits(t_flags);

    // Config side effects for the front end.
    typedef struct packed {
        logic restart;    // geometry write: raster back to first pixel
        logic seed_load;  // seed write: reload LFSR
    } t_cfg_ctl;

endpackage

// ===== src/block_test_pattern_generator.sv =====
// Top level of the block test pattern generator.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------------------------
//  input     | push / full        | i_action, i_tile_col, i_tile_row, i_tile_bit
//  result    | pop / empty        | o_pixel_value, o_end_of_line, o_end_of_frame
//  config    | i_cfg_we           | i_cfg_addr, i_cfg_wdata
//
//  Throughput: one transaction per clock sustained while the result side keeps popping,
//  pixel ticks and tile loads alike. On its way to the result ports a pixel passes the
//  front queue, the store read register and the result queue.
//  Reset is synchronous, active low; no clearing pass, so the block takes
//  transactions from the first cycle after reset.
//  A stall on the result side backs up the two four-entry queues, then full rises.
module block_test_pattern_generator #(
    parameter int MAX_WIDTH  = btpg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = btpg_pkg::MAX_HEIGHT_DEF,
    parameter int TILE_MAX   = btpg_pkg::TILE_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input transactions
    input  logic                            push,
    output logic                            full,
    input  logic                            i_action,
    input  logic [5:0]                      i_tile_col,
    input  logic [5:0]                      i_tile_row,
    input  logic                            i_tile_bit,
    // result transactions
    input  logic                            pop,
    output logic                            empty,
    output logic [7:0]                      o_pixel_value,
    output logic                            o_end_of_line,
    output logic                            o_end_of_frame,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [btpg_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [btpg_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    localparam int XW     = $clog2(MAX_WIDTH);
    localparam int TW     = $clog2(TILE_MAX);
    localparam int MID_W  = btpg_pkg::FLAGS_W + XW + 2*TW;
    localparam int OUT_W  = 10;
    localparam int QCW    = $clog2(btpg_pkg::QUEUE_DEPTH+1);

    // Configuration registers.
    logic [2:0]  r_mode;
    logic [7:0]  r_block_size;
    logic [10:0] r_frame_width;
    logic [10:0] r_frame_height;
    logic [6:0]  r_tile_width;
    logic [6:0]  r_tile_height;

    btpg_pkg::t_cfg_ctl cfg_ctl;

    // Front to back.
    logic                    accept;
    logic                    fe_push;
    btpg_pkg::t_flags        fe_flags, be_flags;
    logic [XW-1:0]           fe_block_col, be_block_col;
    logic [2*TW-1:0]         fe_tile_addr, be_tile_addr;
    logic [MID_W-1:0]        mid_in, mid_out;
    logic                    mid_empty, be_pop;
    logic [QCW-1:0]          mid_count;

    // Back to result queue.
    logic                    be_push;
    logic [7:0]              be_pixel;
    logic                    be_eol, be_eof;
    logic [OUT_W-1:0]        out_in, out_data;
    logic                    out_full;
    logic [QCW-1:0]          out_count;

    // Register writes; geometry writes restart the raster, seed writes reload the LFSR.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= btpg_pkg::RST_MODE;
            r_block_size   <= btpg_pkg::RST_BLOCK_SIZE;
            r_frame_width  <= btpg_pkg::RST_FRAME_WIDTH;
            r_frame_height <= btpg_pkg::RST_FRAME_HEIGHT;
            r_tile_width   <= btpg_pkg::RST_TILE_WIDTH;
            r_tile_height  <= btpg_pkg::RST_TILE_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                btpg_pkg::REG_MODE:         r_mode         <= i_cfg_wdata[2:0];
                btpg_pkg::REG_BLOCK_SIZE:   r_block_size   <= i_cfg_wdata[7:0];
                btpg_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_wdata[10:0];
                btpg_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_wdata[10:0];
                btpg_pkg::REG_TILE_WIDTH:   r_tile_width   <= i_cfg_wdata[6:0];
                btpg_pkg::REG_TILE_HEIGHT:  r_tile_height  <= i_cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg_ctl.restart = i_cfg_we &&
                          ((i_cfg_addr == btpg_pkg::REG_BLOCK_SIZE)   ||
                           (i_cfg_addr == btpg_pkg::REG_FRAME_WIDTH)  ||
                           (i_cfg_addr == btpg_pkg::REG_FRAME_HEIGHT) ||
                           (i_cfg_addr == btpg_pkg::REG_TILE_WIDTH)   ||
                           (i_cfg_addr == btpg_pkg::REG_TILE_HEIGHT));
        cfg_ctl.seed_load = i_cfg_we && (i_cfg_addr == btpg_pkg::REG_RANDOM_SEED);
    end

    // Input side takes a transaction whenever the front queue has space.
    assign accept = push && !full;

    btpg_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .TILE_MAX   (TILE_MAX)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (cfg_ctl),
        .i_seed         (i_cfg_wdata[15:0]),
        .i_block_size   (r_block_size),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_tile_width   (r_tile_width),
        .i_tile_height  (r_tile_height),
        .i_accept       (accept),
        .i_action       (i_action),
        .i_tile_col     (i_tile_col),
        .i_tile_row     (i_tile_row),
        .i_tile_bit     (i_tile_bit),
        .o_push         (fe_push),
        .o_flags        (fe_flags),
        .o_block_col    (fe_block_col),
        .o_tile_addr    (fe_tile_addr)
    );

    assign mid_in = {fe_flags, fe_block_col, fe_tile_addr};

    // Decoupling queue between the raster front and the store back end.
    btpg_queue #(
        .WIDTH (MID_W),
        .DEPTH (btpg_pkg::QUEUE_DEPTH)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_data  (mid_in),
        .o_full  (full),
        .i_pop   (be_pop),
        .o_data  (mid_out),
        .o_empty (mid_empty),
        .o_count (mid_count)
    );

    assign {be_flags, be_block_col, be_tile_addr} = mid_out;

    btpg_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .TILE_MAX  (TILE_MAX)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_mode         (r_mode),
        .i_valid        (!mid_empty && (mid_count != '0)),
        .o_pop          (be_pop),
        .i_flags        (be_flags),
        .i_block_col    (be_block_col),
        .i_tile_addr    (be_tile_addr),
        .i_out_count    (out_count),
        .o_push         (be_push),
        .o_pixel_value  (be_pixel),
        .o_end_of_line  (be_eol),
        .o_end_of_frame (be_eof)
    );

    assign out_in = {be_pixel, be_eol, be_eof};

    // Result queue; the back end only pushes when it holds a credit, so full never blocks.
    btpg_queue #(
        .WIDTH (OUT_W),
        .DEPTH (btpg_pkg::QUEUE_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (be_push && !out_full),
        .i_data  (out_in),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_data),
        .o_empty (empty),
        .o_count (out_count)
    );

    assign {o_pixel_value, o_end_of_line, o_end_of_frame} = out_data;

endmodule

// ===== src/btpg_queue.sv =====
// Small synchronous FIFO used between the pipeline parts.
module btpg_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = btpg_pkg::QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];

    assign wr_en = i_push && !o_full;
    assign rd_en = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH-1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH-1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== src/btpg_front.sv =====
// Front end: raster counters, LFSR and classification of incoming transactions.
module btpg_front #(
    parameter int MAX_WIDTH  = btpg_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = btpg_pkg::MAX_HEIGHT_DEF,
    parameter int TILE_MAX   = btpg_pkg::TILE_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  btpg_pkg::t_cfg_ctl              i_ctl,
    input  logic [15:0]                     i_seed,
    input  logic [7:0]                      i_block_size,
    input  logic [10:0]                     i_frame_width,
    input  logic [10:0]                     i_frame_height,
    input  logic [6:0]                      i_tile_width,
    input  logic [6:0]                      i_tile_height,
    input  logic                            i_accept,
    input  logic                            i_action,
    input  logic [5:0]                      i_tile_col,
    input  logic [5:0]                      i_tile_row,
    input  logic                            i_tile_bit,
    output logic                            o_push,
    output btpg_pkg::t_flags                o_flags,
    output logic [$clog2(MAX_WIDTH)-1:0]    o_block_col,
    output logic [2*$clog2(TILE_MAX)-1:0]   o_tile_addr
);
    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int TW  = $clog2(TILE_MAX);
    localparam int FWW = (XW + 1 > 11) ? XW + 1 : 11;
    localparam int FHW = (YW + 1 > 11) ? YW + 1 : 11;
    localparam int TCW = (TW + 1 > 7) ? TW + 1 : 7;
    localparam int LW  = ((TW > 6) ? TW : 6) + 1;

    logic [XW-1:0] r_pixel_col, n_pixel_col;
    logic [YW-1:0] r_pixel_row, n_pixel_row;
    logic [7:0]    r_in_block_col, n_in_block_col;
    logic [7:0]    r_in_block_row, n_in_block_row;
    logic [XW-1:0] r_block_col, n_block_col;
    logic [YW-1:0] r_block_row, n_block_row;
    logic [TW-1:0] r_tile_col_cnt, n_tile_col_cnt;
    logic [TW-1:0] r_tile_row_cnt, n_tile_row_cnt;
    logic [15:0]   r_lfsr, n_lfsr;

    logic [7:0]     bs;
    logic [FWW-1:0] fw, fw_ext;
    logic [FHW-1:0] fh, fh_ext;
    logic [TCW-1:0] tw, th, tw_ext, th_ext;
    logic [LW-1:0]  ld_col, ld_row;
    logic           tick, load_ok, eol, eof, blk_col_end, blk_row_end;
    logic           tile_col_end, tile_row_end, lfsr_step, lfsr_bit;

    // Clamp sizes: zero acts as one, oversize acts as the limit.
    always_comb begin
        fw_ext = FWW'(i_frame_width);
        fh_ext = FHW'(i_frame_height);
        tw_ext = TCW'(i_tile_width);
        th_ext = TCW'(i_tile_height);
        bs = (i_block_size == 8'd0) ? 8'd1 : i_block_size;
        fw = (fw_ext == '0) ? FWW'(1) :
             (fw_ext > FWW'(MAX_WIDTH)) ? FWW'(MAX_WIDTH) : fw_ext;
        fh = (fh_ext == '0) ? FHW'(1) :
             (fh_ext > FHW'(MAX_HEIGHT)) ? FHW'(MAX_HEIGHT) : fh_ext;
        tw = (tw_ext == '0) ? TCW'(1) :
             (tw_ext > TCW'(TILE_MAX)) ? TCW'(TILE_MAX) : tw_ext;
        th = (th_ext == '0) ? TCW'(1) :
             (th_ext > TCW'(TILE_MAX)) ? TCW'(TILE_MAX) : th_ext;
    end

    assign tick   = i_accept && (i_action == btpg_pkg::ACT_PIXEL);
    assign ld_col = LW'(i_tile_col);
    assign ld_row = LW'(i_tile_row);
    assign load_ok = (ld_col < LW'(TILE_MAX)) && (ld_row < LW'(TILE_MAX));

    assign eol = ((FWW'(r_pixel_col) + FWW'(1)) >= fw);
    assign eof = eol && ((FHW'(r_pixel_row) + FHW'(1)) >= fh);
    assign blk_col_end  = (({1'b0, r_in_block_col} + 9'd1) >= {1'b0, bs});
    assign blk_row_end  = (({1'b0, r_in_block_row} + 9'd1) >= {1'b0, bs});
    assign tile_col_end = ((TCW'(r_tile_col_cnt) + TCW'(1)) >= tw);
    assign tile_row_end = ((TCW'(r_tile_row_cnt) + TCW'(1)) >= th);

    // Fibonacci LFSR, taps 16,14,13,11, shifting right.
    assign lfsr_step = tick && (r_in_block_row == 8'd0) && (r_in_block_col == 8'd0);
    assign lfsr_bit  = r_lfsr[0] ^ r_lfsr[2] ^ r_lfsr[3] ^ r_lfsr[5];

    always_comb begin
        n_pixel_col    = r_pixel_col;
        n_pixel_row    = r_pixel_row;
        n_in_block_col = r_in_block_col;
        n_in_block_row = r_in_block_row;
        n_block_col    = r_block_col;
        n_block_row    = r_block_row;
        n_tile_col_cnt = r_tile_col_cnt;
        n_tile_row_cnt = r_tile_row_cnt;
        n_lfsr         = r_lfsr;

        if (lfsr_step) begin
            n_lfsr = {lfsr_bit, r_lfsr[15:1]};
        end
        if (i_ctl.seed_load) begin
            n_lfsr = (i_seed == 16'd0) ? 16'd1 : i_seed;
        end

        if (tick) begin
            if (!eol) begin
                n_pixel_col = r_pixel_col + 1'b1;
                if (blk_col_end) begin
                    n_in_block_col = 8'd0;
                    n_block_col    = r_block_col + 1'b1;
                    n_tile_col_cnt = tile_col_end ? '0 : r_tile_col_cnt + 1'b1;
                end else begin
                    n_in_block_col = r_in_block_col + 8'd1;
                end
            end else begin
                n_pixel_col    = '0;
                n_in_block_col = 8'd0;
                n_block_col    = '0;
                n_tile_col_cnt = '0;
                if (eof) begin
                    n_pixel_row    = '0;
                    n_in_block_row = 8'd0;
                    n_block_row    = '0;
                    n_tile_row_cnt = '0;
                end else begin
                    n_pixel_row = r_pixel_row + 1'b1;
                    if (blk_row_end) begin
                        n_in_block_row = 8'd0;
                        n_block_row    = r_block_row + 1'b1;
                        n_tile_row_cnt = tile_row_end ? '0 : r_tile_row_cnt + 1'b1;
                    end else begin
                        n_in_block_row = r_in_block_row + 8'd1;
                    end
                end
            end
        end

        if (i_ctl.restart) begin
            n_pixel_col    = '0;
            n_pixel_row    = '0;
            n_in_block_col = 8'd0;
            n_in_block_row = 8'd0;
            n_block_col    = '0;
            n_block_row    = '0;
            n_tile_col_cnt = '0;
            n_tile_row_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_col    <= '0;
            r_pixel_row    <= '0;
            r_in_block_col <= 8'd0;
            r_in_block_row <= 8'd0;
            r_block_col    <= '0;
            r_block_row    <= '0;
            r_tile_col_cnt <= '0;
            r_tile_row_cnt <= '0;
            r_lfsr         <= btpg_pkg::RST_SEED;
        end else begin
            r_pixel_col    <= n_pixel_col;
            r_pixel_row    <= n_pixel_row;
            r_in_block_col <= n_in_block_col;
            r_in_block_row <= n_in_block_row;
            r_block_col    <= n_block_col;
            r_block_row    <= n_block_row;
            r_tile_col_cnt <= n_tile_col_cnt;
            r_tile_row_cnt <= n_tile_row_cnt;
            r_lfsr         <= n_lfsr;
        end
    end

    // Out-of-range loads are accepted and dropped here.
    assign o_push = tick || (i_accept && (i_action == btpg_pkg::ACT_LOAD) && load_ok);

    always_comb begin
        o_flags.is_load  = (i_action == btpg_pkg::ACT_LOAD);
        o_flags.tile_bit = i_tile_bit;
        o_flags.rand_we  = lfsr_step;
        o_flags.rand_bit = lfsr_bit;
        o_flags.col_par  = r_block_col[0];
        o_flags.row_par  = r_block_row[0];
        o_flags.eol      = eol;
        o_flags.eof      = eof;
    end

    assign o_block_col = r_block_col;
    assign o_tile_addr = (i_action == btpg_pkg::ACT_LOAD) ?
                         {ld_row[TW-1:0], ld_col[TW-1:0]} :
                         {r_tile_row_cnt, r_tile_col_cnt};

endmodule

// ===== src/btpg_back.sv =====
// Back end: line store, tile store and pixel value selection.
module btpg_back #(
    parameter int MAX_WIDTH = btpg_pkg::MAX_WIDTH_DEF,
    parameter int TILE_MAX  = btpg_pkg::TILE_MAX_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic [2:0]                                  i_mode,
    input  logic                                        i_valid,
    output logic                                        o_pop,
    input  btpg_pkg::t_flags                            i_flags,
    input  logic [$clog2(MAX_WIDTH)-1:0]                i_block_col,
    input  logic [2*$clog2(TILE_MAX)-1:0]               i_tile_addr,
    input  logic [$clog2(btpg_pkg::QUEUE_DEPTH+1)-1:0]  i_out_count,
    output logic                                        o_push,
    output logic [7:0]                                  o_pixel_value,
    output logic                                        o_end_of_line,
    output logic                                        o_end_of_frame
);
    localparam int TW  = $clog2(TILE_MAX);
    localparam int QCW = $clog2(btpg_pkg::QUEUE_DEPTH+1);

    logic                 rand_mem [MAX_WIDTH];
    logic                 tile_mem [2**(2*TW)];
    logic                 r_valid;
    btpg_pkg::t_flags     r_flags;
    logic                 r_rand_rd, r_tile_rd;
    logic                 busy_pixel, room, white;
    logic [QCW:0]         pending;

    // Credit check: queued results plus the one in flight must fit.
    assign busy_pixel = r_valid && !r_flags.is_load;
    assign pending    = {1'b0, i_out_count} + (QCW+1)'(busy_pixel);
    assign room       = (pending < (QCW+1)'(btpg_pkg::QUEUE_DEPTH));
    assign o_pop      = i_valid && room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_flags <= i_flags;
        end
    end

    // Line store: write-first on the block's first pixel.
    always_ff @(posedge i_clk) begin
        if (o_pop && i_flags.rand_we) begin
            rand_mem[i_block_col] <= i_flags.rand_bit;
        end
        if (o_pop) begin
            r_rand_rd <= i_flags.rand_we ? i_flags.rand_bit : rand_mem[i_block_col];
        end
    end

    // Tile store: loads write, pixel transactions read.
    always_ff @(posedge i_clk) begin
        if (o_pop && i_flags.is_load) begin
            tile_mem[i_tile_addr] <= i_flags.tile_bit;
        end
        if (o_pop) begin
            r_tile_rd <= tile_mem[i_tile_addr];
        end
    end

    always_comb begin
        case (i_mode)
            btpg_pkg::MODE_WHITE:   white = 1'b1;
            btpg_pkg::MODE_CHECKER: white = (r_flags.col_par == r_flags.row_par);
            btpg_pkg::MODE_STRIPES: white = r_flags.row_par;
            btpg_pkg::MODE_RANDOM:  white = r_rand_rd;
            btpg_pkg::MODE_TILED:   white = r_tile_rd;
            default:                white = 1'b0;
        endcase
    end

    assign o_push         = busy_pixel;
    assign o_pixel_value  = white ? btpg_pkg::PIX_WHITE : btpg_pkg::PIX_BLACK;
    assign o_end_of_line  = r_flags.eol;
    assign o_end_of_frame = r_flags.eof;

endmodule

// ===== src/btpg_checker.sv =====
// Port-level checker for the block test pattern generator, bound to the top level.
`include "assert_macros.svh"

module btpg_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       pop,
    input logic       empty,
    input logic [7:0] o_pixel_value,
    input logic       o_end_of_line,
    input logic       o_end_of_frame
);

    // Pixels are pure black or pure white.
    `BTPG_ASSERT(a_pixel_levels, i_clk, i_rst_n, !empty |-> (o_pixel_value == 8'h00 || o_pixel_value == 8'hFF), "pixel value neither black nor white")

    // The last pixel of a frame is also the last of its line.
    `BTPG_ASSERT(a_eof_has_eol, i_clk, i_rst_n, (!empty && o_end_of_frame) |-> o_end_of_line, "end of frame without end of line")

    // A waiting result holds until taken.
    `BTPG_ASSERT(a_result_holds, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_pixel_value) && $stable(o_end_of_line) && $stable(o_end_of_frame)), "waiting result changed or vanished")

    // Reset drops every pending result.
    `BTPG_ASSERT_ALWAYS(a_reset_empties, i_clk, !i_rst_n |=> empty, "results pending after reset")

endmodule

bind block_test_pattern_generator btpg_checker u_btpg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .pop            (pop),
    .empty          (empty),
    .o_pixel_value  (o_pixel_value),
    .o_end_of_line  (o_end_of_line),
    .o_end_of_frame (o_end_of_frame)
);

// ===== tb/block_test_pattern_generator_tb.sv =====
// Testbench of the block test pattern generator: raster predictor, result scoreboard, stimulus.
`timescale 1ns / 1ps

module block_test_pattern_generator_tb;
    import btpg_pkg::*;

    // Register index with no register behind it, and the two mode codes with no pattern.
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED     = 3'd7;
    localparam logic [2:0]            MODE_UNUSED_LO = 3'd6;
    localparam logic [2:0]            MODE_UNUSED_HI = 3'd7;

    localparam int CYCLE_LIMIT  = 1_000_000;  // watchdog, far beyond the slowest legal run
    localparam int LONG_HOLD    = 60;         // result side hold-off, fills both queues
    localparam int DRAIN_CYCLES = 8;          // covers loads in flight, which leave no result behind
    localparam int BULK_ITEMS   = 1350;       // random part, before the calm tail
    localparam int CALM_ITEMS   = 200;        // last part, no idling on either side

    // One predicted pixel transaction.
    typedef struct {
        logic [7:0] pix;
        logic       eol;
        logic       eof;
    } pixel_t;

    typedef struct {
        logic [CFG_ADDR_W-1:0] idx;
        logic [CFG_DATA_W-1:0] data;
    } reg_write_t;

    // Raster predictor plus the queue of pixels it still owes the result side.
    class pattern_scoreboard;
        logic [2:0]  mode;
        logic [7:0]  block_size;
        logic [10:0] frame_width, frame_height;
        logic [6:0]  tile_width, tile_height;
        logic [15:0] lfsr;
        int unsigned pix_col, pix_row, sub_col, sub_row;
        int unsigned blk_col, blk_row, rep_col, rep_row;
        bit          block_bits[MAX_WIDTH_DEF];
        bit          tile_bits[TILE_MAX_DEF][TILE_MAX_DEF];
        pixel_t      owed_pixels[$];
        int          errors;

        function new();
            mode         = RST_MODE;
            block_size   = RST_BLOCK_SIZE;
            frame_width  = RST_FRAME_WIDTH;
            frame_height = RST_FRAME_HEIGHT;
            tile_width   = RST_TILE_WIDTH;
            tile_height  = RST_TILE_HEIGHT;
            lfsr         = RST_SEED;
            errors       = 0;
            restart();
        endfunction

        // Zero acts as one, anything above the limit as the limit.
        function int unsigned clamp_size(int unsigned v, int unsigned hi);
            if (v == 0) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function void restart();
            pix_col = 0; pix_row = 0; sub_col = 0; sub_row = 0;
            blk_col = 0; blk_row = 0; rep_col = 0; rep_row = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_MODE:         mode = data[2:0];
                REG_BLOCK_SIZE:   begin block_size = data[7:0];    restart(); end
                REG_FRAME_WIDTH:  begin frame_width = data[10:0];  restart(); end
                REG_FRAME_HEIGHT: begin frame_height = data[10:0]; restart(); end
                REG_TILE_WIDTH:   begin tile_width = data[6:0];    restart(); end
                REG_TILE_HEIGHT:  begin tile_height = data[6:0];   restart(); end
                REG_RANDOM_SEED:  lfsr = (data == 16'd0) ? 16'd1 : data;
                default: ;
            endcase
        endfunction

        function void note_item(logic action, logic [5:0] t_col, logic [5:0] t_row,
                                logic t_bit);
            int unsigned bs, fw, fh, tw, th;
            logic        white, fb;
            pixel_t      px;
            if (action == ACT_LOAD) begin
                tile_bits[t_row][t_col] = t_bit;
                return;
            end
            bs = clamp_size(block_size, 255);
            fw = clamp_size(frame_width, MAX_WIDTH_DEF);
            fh = clamp_size(frame_height, MAX_HEIGHT_DEF);
            tw = clamp_size(tile_width, TILE_MAX_DEF);
            th = clamp_size(tile_height, TILE_MAX_DEF);
            // LFSR steps at the top-left pixel of each block, whatever the mode
            if (sub_row == 0 && sub_col == 0 && blk_col < MAX_WIDTH_DEF) begin
                fb = lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5];
                lfsr = {fb, lfsr[15:1]};
                block_bits[blk_col] = fb;
            end
            case (mode)
                MODE_WHITE:   white = 1'b1;
                MODE_CHECKER: white = ((blk_col ^ blk_row) & 1) == 0;
                MODE_STRIPES: white = (blk_row & 1) != 0;
                MODE_RANDOM:  white = (blk_col < MAX_WIDTH_DEF) ? block_bits[blk_col] : 1'b0;
                MODE_TILED:   white = tile_bits[rep_row][rep_col];
                default:      white = 1'b0;
            endcase
            px.pix = white ? PIX_WHITE : PIX_BLACK;
            px.eol = (pix_col + 1 >= fw);
            px.eof = px.eol && (pix_row + 1 >= fh);
            owed_pixels.push_back(px);
            if (!px.eol) begin
                pix_col++;
                if (sub_col + 1 >= bs) begin
                    sub_col = 0;
                    blk_col++;
                    rep_col = (rep_col + 1 >= tw) ? 0 : rep_col + 1;
                end else begin
                    sub_col++;
                end
            end else begin
                pix_col = 0; sub_col = 0; blk_col = 0; rep_col = 0;
                if (px.eof) begin
                    pix_row = 0; sub_row = 0; blk_row = 0; rep_row = 0;
                end else begin
                    pix_row++;
                    if (sub_row + 1 >= bs) begin
                        sub_row = 0;
                        blk_row++;
                        rep_row = (rep_row + 1 >= th) ? 0 : rep_row + 1;
                    end else begin
                        sub_row++;
                    end
                end
            end
        endfunction

        function void check_pixel(logic [7:0] pix, logic eol, logic eof);
            pixel_t px;
            if (owed_pixels.size() == 0) begin
                $error("unexpected pixel: pixel_value %0d end_of_line %0b end_of_frame %0b",
                       pix, eol, eof);
                errors++;
                return;
            end
            px = owed_pixels.pop_front();
            if (pix !== px.pix) begin
                $error("pixel_value: expected %0d, actual %0d", px.pix, pix);
                errors++;
            end
            if (eol !== px.eol) begin
                $error("end_of_line: expected %0b, actual %0b", px.eol, eol);
                errors++;
            end
            if (eof !== px.eof) begin
                $error("end_of_frame: expected %0b, actual %0b", px.eof, eof);
                errors++;
            end
        endfunction

        function void check_drained();
            if (owed_pixels.size() != 0) begin
                $error("%0d pixels never arrived", owed_pixels.size());
                errors++;
            end
        endfunction
    endclass

    // DUT signals
    logic                  i_clk;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    logic                  i_action;
    logic [5:0]            i_tile_col;
    logic [5:0]            i_tile_row;
    logic                  i_tile_bit;
    logic                  pop;
    logic                  empty;
    logic [7:0]            o_pixel_value;
    logic                  o_end_of_line;
    logic                  o_end_of_frame;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    pattern_scoreboard sb = new();

    // Tile entries loaded so far; tiled mode only ever reads loaded ones.
    bit tile_loaded[TILE_MAX_DEF][TILE_MAX_DEF];

    reg_write_t  reg_batch[$];
    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;
    bit          tx_idle = 1'b1;   // sender may insert gaps
    bit          rx_idle = 1'b1;   // receiver may insert stalls
    bit          hold_req = 1'b0;  // ask the receiver for one long hold-off

    block_test_pattern_generator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_action       (i_action),
        .i_tile_col     (i_tile_col),
        .i_tile_row     (i_tile_row),
        .i_tile_bit     (i_tile_bit),
        .pop            (pop),
        .empty          (empty),
        .o_pixel_value  (o_pixel_value),
        .o_end_of_line  (o_end_of_line),
        .o_end_of_frame (o_end_of_frame),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    // 2 ns clock
    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Watchdog: a hung handshake or a lost pixel ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Result monitor: every popped transaction is checked against the oldest owed pixel.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            sb.check_pixel(o_pixel_value, o_end_of_line, o_end_of_frame);
        end
    end

    // Result side driver. Pop changes at the falling edge only. Random stalls while
    // rx_idle is set; a long hold-off on request, counted here.
    initial begin : result_taker
        int unsigned gap;
        pop = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                pop = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (rx_idle && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 17);
                pop = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                pop = 1'b1;
            end
        end
    end

    // Offer one input transaction. Entered and left at a falling edge; push is left
    // high so back-to-back transactions follow without a gap.
    task automatic send_item(input logic action, input logic [5:0] t_col,
                             input logic [5:0] t_row, input logic t_bit);
        int unsigned gap;
        if (tx_idle && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            push = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push       = 1'b1;
        i_action   = action;
        i_tile_col = t_col;
        i_tile_row = t_row;
        i_tile_bit = t_bit;
        do @(posedge i_clk); while (full);
        sb.note_item(action, t_col, t_row, t_bit);
        if (action == ACT_LOAD) tile_loaded[t_row][t_col] = 1'b1;
        items_sent++;
        @(negedge i_clk);
    endtask

    // Stop offering and wait for every owed pixel, then for loads still in flight.
    task automatic drain();
        push = 1'b0;
        while (sb.owed_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Fill the part of the tile store that the current tile size can reach.
    task automatic load_tile_window();
        int unsigned tw, th;
        tw = sb.clamp_size(sb.tile_width, TILE_MAX_DEF);
        th = sb.clamp_size(sb.tile_height, TILE_MAX_DEF);
        for (int unsigned r = 0; r < th; r++) begin
            for (int unsigned c = 0; c < tw; c++) begin
                if (!tile_loaded[r][c]) send_item(ACT_LOAD, 6'(c), 6'(r), 1'($urandom));
            end
        end
    endtask

    function automatic void add_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        reg_write_t w;
        w.idx  = idx;
        w.data = data;
        reg_batch.push_back(w);
    endfunction

    // Same, with random junk above the register's width (must be ignored).
    function automatic void add_reg_junk(logic [CFG_ADDR_W-1:0] idx, int unsigned v,
                                         int unsigned width);
        add_reg(idx, 16'($urandom << width) | 16'(v));
    endfunction

    // Write the batched registers; block is idle here. Tiled mode gets its tiles first.
    task automatic program_regs();
        foreach (reg_batch[k]) begin
            i_cfg_we    = 1'b1;
            i_cfg_addr  = reg_batch[k].idx;
            i_cfg_wdata = reg_batch[k].data;
            @(posedge i_clk);
            sb.write_reg(reg_batch[k].idx, reg_batch[k].data);
            @(negedge i_clk);
        end
        i_cfg_we = 1'b0;
        reg_batch.delete();
        if (sb.mode == MODE_TILED) load_tile_window();
    endtask

    // Pixel ticks with random (ignored) side fields, mixed with random tile loads.
    task automatic run_phase(input int unsigned count, input int unsigned load_pct);
        for (int unsigned k = 0; k < count; k++) begin
            if ($urandom_range(0, 99) < load_pct)
                send_item(ACT_LOAD, 6'($urandom), 6'($urandom), 1'($urandom));
            else
                send_item(ACT_PIXEL, 6'($urandom), 6'($urandom), 1'($urandom));
        end
        drain();
    endtask

    // Random settings, mostly small frames so lines and frames wrap often. Tile sizes
    // are written as a pair with one side kept tiny when the other is large, so the
    // reachable tile window stays cheap to load.
    task automatic pick_random_setup();
        int unsigned tw, th;
        if ($urandom_range(0, 4) != 0) add_reg_junk(REG_MODE, $urandom_range(0, 7), 3);
        if ($urandom_range(0, 1) != 0)
            add_reg_junk(REG_BLOCK_SIZE, ($urandom_range(0, 3) == 0) ?
                         $urandom_range(0, 255) : $urandom_range(0, 6), 8);
        if ($urandom_range(0, 1) != 0)
            add_reg_junk(REG_FRAME_WIDTH, ($urandom_range(0, 4) == 0) ?
                         $urandom_range(0, 80) : $urandom_range(0, 24), 11);
        if ($urandom_range(0, 1) != 0)
            add_reg_junk(REG_FRAME_HEIGHT, ($urandom_range(0, 4) == 0) ?
                         $urandom_range(0, 40) : $urandom_range(0, 12), 11);
        if ($urandom_range(0, 1) != 0) begin
            tw = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 8);
            if (tw > 8) th = $urandom_range(0, 2);
            else th = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 8);
            if (tw > 2 && th > 8) th = $urandom_range(0, 8);
            add_reg_junk(REG_TILE_WIDTH, tw, 7);
            add_reg_junk(REG_TILE_HEIGHT, th, 7);
        end
        if ($urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
                0:       add_reg(REG_RANDOM_SEED, 16'h0000);
                1:       add_reg(REG_RANDOM_SEED, 16'hFFFF);
                default: add_reg(REG_RANDOM_SEED, 16'($urandom));
            endcase
        end
        if ($urandom_range(0, 9) == 0) add_reg(REG_UNUSED, 16'($urandom));
    endtask

    initial begin : stimulus
        int unsigned bulk_start;
        int unsigned phase;
        i_rst_n     = 1'b0;
        push        = 1'b0;
        i_action    = ACT_PIXEL;
        i_tile_col  = 6'd0;
        i_tile_row  = 6'd0;
        i_tile_bit  = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = REG_MODE;
        i_cfg_wdata = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // ---- Directed part ----
        // Reset settings (black, 8-pixel blocks); extreme side fields on ticks and
        // loads at the four corners of the tile store. Loads give no pixel.
        send_item(ACT_PIXEL, 6'd63, 6'd63, 1'b1);
        send_item(ACT_PIXEL, 6'd0, 6'd0, 1'b0);
        send_item(ACT_LOAD, 6'd0, 6'd0, 1'b1);
        send_item(ACT_LOAD, 6'd63, 6'd63, 1'b0);
        send_item(ACT_LOAD, 6'd63, 6'd0, 1'b1);
        send_item(ACT_LOAD, 6'd0, 6'd63, 1'b0);
        send_item(ACT_PIXEL, 6'd21, 6'd42, 1'b1);
        drain();

        // Write to the register index with nothing behind it, then both spare modes:
        // black, raster untouched.
        add_reg(REG_UNUSED, 16'hFFFF);
        add_reg(REG_MODE, 16'(MODE_UNUSED_LO));
        program_regs();
        send_item(ACT_PIXEL, 6'd0, 6'd0, 1'b0);
        send_item(ACT_PIXEL, 6'd0, 6'd0, 1'b0);
        drain();
        add_reg(REG_MODE, {13'h1FFF, MODE_UNUSED_HI});
        program_regs();
        send_item(ACT_PIXEL, 6'd0, 6'd0, 1'b0);
        drain();

        // Zero seed loads 1; zero block size and width act as 1: every pixel ends a
        // line, every second one ends the frame, and the LFSR steps per pixel.
        add_reg(REG_MODE, 16'(MODE_RANDOM));
        add_reg(REG_RANDOM_SEED, 16'h0000);
        add_reg(REG_BLOCK_SIZE, 16'h0000);
        add_reg(REG_FRAME_WIDTH, 16'h0000);
        add_reg(REG_FRAME_HEIGHT, 16'd2);
        program_regs();
        repeat (4) send_item(ACT_PIXEL, 6'd0, 6'd0, 1'b0);
        drain();

        // Geometry write mid-line restarts the raster; zero tile sizes act as 1x1
        // (entry 0,0 was loaded above).
        add_reg(REG_MODE, 16'(MODE_CHECKER));
        add_reg(REG_BLOCK_SIZE, 16'd2);
        add_reg(REG_FRAME_WIDTH, 16'd5);
        add_reg(REG_FRAME_HEIGHT, 16'd3);
        program_regs();
        repeat (3) send_item(ACT_PIXEL, 6'd0, 6'd0, 1'b0);
        drain();
        add_reg(REG_TILE_WIDTH, 16'h0000);
        add_reg(REG_TILE_HEIGHT, 16'h0000);
        add_reg(REG_MODE, 16'(MODE_TILED));
        program_regs();
        repeat (3) send_item(ACT_PIXEL, 6'd0, 6'd0, 1'b0);
        drain();

        // ---- Extreme settings ----
        // Widest tile repeat (127 acts as 64) over one-pixel blocks, one tile row.
        add_reg(REG_BLOCK_SIZE, 16'd0);
        add_reg(REG_FRAME_WIDTH, 16'd100);
        add_reg(REG_FRAME_HEIGHT, 16'd3);
        add_reg(REG_TILE_WIDTH, 16'd127);
        add_reg(REG_TILE_HEIGHT, 16'd1);
        program_regs();
        run_phase(300, 5);

        // Tallest tile repeat, one tile column.
        add_reg(REG_BLOCK_SIZE, 16'd1);
        add_reg(REG_FRAME_WIDTH, 16'd2);
        add_reg(REG_FRAME_HEIGHT, 16'd70);
        add_reg(REG_TILE_WIDTH, 16'd1);
        add_reg(REG_TILE_HEIGHT, 16'd64);
        program_regs();
        run_phase(150, 5);

        // Width 2047 acts as 1024: first end-of-line after 1024 pixels; 255-pixel
        // blocks give checker transitions along the line.
        add_reg(REG_MODE, 16'(MODE_CHECKER));
        add_reg(REG_BLOCK_SIZE, 16'd255);
        add_reg(REG_FRAME_WIDTH, 16'd2047);
        add_reg(REG_FRAME_HEIGHT, 16'd1);
        program_regs();
        run_phase(1030, 3);

        // Height 2047 acts as 1024 on a one-pixel-wide frame; stripes flip every 255 lines.
        add_reg(REG_MODE, 16'(MODE_STRIPES));
        add_reg(REG_FRAME_WIDTH, 16'd1);
        add_reg(REG_FRAME_HEIGHT, 16'd2047);
        program_regs();
        run_phase(1030, 3);

        // ---- Random part ----
        // Every phase starts from an idle block: the sender waits for all owed pixels
        // before the settings change. Two phases hold off the result side for a long
        // stretch while the sender keeps pushing, so full must rise and stall it.
        bulk_start = items_sent;
        phase = 0;
        while (items_sent - bulk_start < BULK_ITEMS) begin
            pick_random_setup();
            program_regs();
            if (phase == 2 || phase == 7) begin
                tx_idle  = 1'b0;
                hold_req = 1'b1;
                run_phase($urandom_range(60, 120), 10);
                tx_idle  = 1'b1;
            end else begin
                // Some phases run without sender gaps.
                tx_idle = ($urandom_range(0, 3) != 0);
                run_phase($urandom_range(20, 120), 15);
                tx_idle = 1'b1;
            end
            phase++;
        end

        // Calm tail: full rate on both sides.
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        pick_random_setup();
        program_regs();
        run_phase(CALM_ITEMS, 10);

        sb.check_drained();
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/btpg_pkg.sv
src/btpg_queue.sv
src/btpg_front.sv
src/btpg_back.sv
src/block_test_pattern_generator.sv
src/btpg_checker.sv
tb/block_test_pattern_generator_tb.sv
